[hdl/button_press_hold_classifier_core_assert.svh]
// Assertion macros shared by the button classifier modules.
`ifndef BUTTON_PRESS_HOLD_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_HOLD_CLASSIFIER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPHC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BPHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

`endif

[hdl/bphc_pkg.sv]
// Shared types, constants and register indexes of the button classifier.
package bphc_pkg;

  // Number of button fields carried on the ports.
  localparam int FIELD_BUTTONS = 3;

  // Defaults for the top-level parameters.
  localparam int NUM_BUTTONS_DEF = 3;
  localparam int COUNT_WIDTH_DEF = 16;

  // Port widths.
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ELAPSED_W = 8;
  localparam int LIMIT_W = 15;
  localparam int DELAY_W = 16;
  localparam int REPEAT_W = 16;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_MASK = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BOUNCE_LIMIT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_LIMIT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_EXIT_COUNT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_REP_PERIOD_A = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REP_PERIOD_B = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_REP_PERIOD_C = 3'd6;

  // Register reset values.
  localparam logic [FIELD_BUTTONS-1:0] ENABLE_MASK_RST = 3'd0;
  localparam logic [LIMIT_W-1:0] BOUNCE_LIMIT_RST = 15'd2;
  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RST = 15'd50;
  localparam logic [DELAY_W-1:0] EXIT_COUNT_RST = 16'hFFF6;
  localparam logic [REPEAT_W-1:0] REP_PERIOD_RST = 16'd0;

  // Button state codes.
  typedef enum logic [1:0] {
    ST_RELEASED = 2'd0,
    ST_SHORT    = 2'd1,
    ST_HOLD     = 2'd2
  } bphc_state_t;

  // Shared limits that every lane sees.
  typedef struct packed {
    logic [LIMIT_W-1:0] bounce_limit;
    logic [LIMIT_W-1:0] hold_limit;
    logic [DELAY_W-1:0] exit_count;
  } bphc_cfg_t;

  // What one lane reports for the current word.
  typedef struct packed {
    logic [1:0] status;
    logic       short_ev;
    logic       hold_ev;
  } bphc_res_t;

endpackage

[hdl/bphc_lane.sv]
// One button lane: press counter, state, repeat timer and event logic.
`include "button_press_hold_classifier_core_assert.svh"

module bphc_lane #(
  parameter int COUNT_WIDTH = bphc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 step,
  input  logic                                 enable,
  input  logic                                 level,
  input  logic [bphc_pkg::ELAPSED_W-1:0]       elapsed_ms,
  input  bphc_pkg::bphc_cfg_t                  cfg,
  input  logic [bphc_pkg::REPEAT_W-1:0]        rep_period,
  output bphc_pkg::bphc_res_t                  res
);

  // Compare width that covers the counter, the 15-bit limits and the 16-bit exit count.
  localparam int CMPW = ((COUNT_WIDTH > bphc_pkg::DELAY_W) ? COUNT_WIDTH
                                                           : bphc_pkg::DELAY_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [CMPW-1:0] CNT_MIN_EXT =
    {{(CMPW-COUNT_WIDTH+1){1'b1}}, {(COUNT_WIDTH-1){1'b0}}};

  logic [COUNT_WIDTH-1:0]         cnt_r, cnt_nxt;
  bphc_pkg::bphc_state_t          state_r, state_nxt;
  logic [bphc_pkg::REPEAT_W-1:0]  timer_r, timer_nxt;
  logic                           fired_r, fired_nxt;

  logic [COUNT_WIDTH-1:0]         cnt_inc;
  logic [COUNT_WIDTH-1:0]         cnt_mid;
  logic signed [CMPW-1:0]         mid_ext;
  logic signed [CMPW-1:0]         bounce_ext;
  logic signed [CMPW-1:0]         hold_ext;
  logic signed [CMPW-1:0]         delay_ext;
  logic signed [CMPW-1:0]         delay_clip;
  logic [bphc_pkg::REPEAT_W:0]    timer_sum;
  logic [bphc_pkg::REPEAT_W-1:0]  timer_sat;
  logic                           entered;
  logic                           short_ev;
  logic                           hold_ev;
  logic                           nxt_is_short;
  logic                           cur_is_short;
  logic                           cur_is_hold;

  // Counter step and sign-extended operands for the limit compares.
  always_comb begin
    cnt_inc = cnt_r + COUNT_WIDTH'(1);
    if (level) begin
      cnt_mid = (cnt_r != CNT_MAX) ? cnt_inc : cnt_r;
    end else begin
      cnt_mid = cnt_r[COUNT_WIDTH-1] ? cnt_inc : cnt_r;
    end
    mid_ext    = {{(CMPW-COUNT_WIDTH){cnt_mid[COUNT_WIDTH-1]}}, cnt_mid};
    bounce_ext = {{(CMPW-bphc_pkg::LIMIT_W){1'b0}}, cfg.bounce_limit};
    hold_ext   = {{(CMPW-bphc_pkg::LIMIT_W){1'b0}}, cfg.hold_limit};
    delay_ext  = {{(CMPW-bphc_pkg::DELAY_W){cfg.exit_count[bphc_pkg::DELAY_W-1]}},
                  cfg.exit_count};
    delay_clip = (delay_ext > 0) ? '0 : delay_ext;
    if (delay_clip < CNT_MIN_EXT) begin
      delay_clip = CNT_MIN_EXT;
    end
    timer_sum = {1'b0, timer_r} + {{(bphc_pkg::REPEAT_W-bphc_pkg::ELAPSED_W+1){1'b0}},
                                    elapsed_ms};
    timer_sat = timer_sum[bphc_pkg::REPEAT_W] ? '1 : timer_sum[bphc_pkg::REPEAT_W-1:0];
  end

  // Next state, count, repeat timer and short and hold events for one scan tick.
  always_comb begin
    bphc_pkg::bphc_state_t st;
    st        = state_r;
    entered   = 1'b0;
    short_ev  = 1'b0;
    hold_ev   = 1'b0;
    cnt_nxt   = cnt_mid;
    timer_nxt = timer_r;
    fired_nxt = fired_r;
    if (st == bphc_pkg::ST_SHORT) begin
      st = bphc_pkg::ST_RELEASED;
    end
    if (level) begin
      if (st != bphc_pkg::ST_HOLD && mid_ext >= hold_ext) begin
        st      = bphc_pkg::ST_HOLD;
        entered = 1'b1;
      end
    end else begin
      if (st == bphc_pkg::ST_HOLD) begin
        st      = bphc_pkg::ST_RELEASED;
        cnt_nxt = delay_clip[COUNT_WIDTH-1:0];
      end else if (!cnt_mid[COUNT_WIDTH-1]) begin
        // A release between the limits is a short press; anything else clears.
        if (mid_ext > bounce_ext && mid_ext < hold_ext) begin
          st = bphc_pkg::ST_SHORT;
        end
        cnt_nxt = '0;
      end
    end
    case (st)
      bphc_pkg::ST_SHORT: begin
        short_ev = 1'b1;
      end
      bphc_pkg::ST_HOLD: begin
        if (entered) begin
          hold_ev   = 1'b1;
          fired_nxt = 1'b1;
          timer_nxt = '0;
        end else if (rep_period != '0 && fired_r) begin
          if (timer_sat >= rep_period) begin
            hold_ev   = 1'b1;
            timer_nxt = '0;
          end else begin
            timer_nxt = timer_sat;
          end
        end
      end
      default: begin
        fired_nxt = 1'b0;
        timer_nxt = '0;
      end
    endcase
    state_nxt = st;
  end

  // A disabled lane keeps its state and reports no events.
  always_comb begin
    res.status   = enable ? state_nxt : state_r;
    res.short_ev = enable & short_ev;
    res.hold_ev  = enable & hold_ev;
  end

  // Lane state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      state_r <= bphc_pkg::ST_RELEASED;
      timer_r <= '0;
      fired_r <= 1'b0;
    end else if (step && enable) begin
      cnt_r   <= cnt_nxt;
      state_r <= state_nxt;
      timer_r <= timer_nxt;
      fired_r <= fired_nxt;
    end
  end

  // State decodes used by the checks below.
  assign nxt_is_short = (state_nxt == bphc_pkg::ST_SHORT);
  assign cur_is_short = (state_r == bphc_pkg::ST_SHORT);
  assign cur_is_hold  = (state_r == bphc_pkg::ST_HOLD);

  // A short press lasts a single tick.
  `BPHC_ASSERT_NEXT(a_short_one_tick, step && enable && nxt_is_short, cur_is_short)
  `BPHC_ASSERT_NOW(a_short_not_twice, cur_is_short, !nxt_is_short)
  // Entering hold always fires a hold event.
  `BPHC_ASSERT_NOW(a_hold_on_entry, enable && !cur_is_hold && res.status == bphc_pkg::ST_HOLD, res.hold_ev)

endmodule

[hdl/bphc_merge.sv]
// Merge stage: packs the lane results into a word and buffers two words.
`include "button_press_hold_classifier_core_assert.svh"

module bphc_merge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  bphc_pkg::bphc_res_t                 lane_res [bphc_pkg::FIELD_BUTTONS],
  output logic                                space_ok,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bphc_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int NB = bphc_pkg::FIELD_BUTTONS;

  logic [bphc_pkg::OUT_TDATA_W-1:0] word;
  logic [bphc_pkg::OUT_TDATA_W-1:0] buf_r [2];
  logic                             wr_ptr_r, rd_ptr_r;
  logic [1:0]                       cnt_r, cnt_nxt;
  logic                             pop;

  // Pack statuses, then short events, then hold events, lowest bits first.
  always_comb begin
    word = '0;
    for (int i = 0; i < NB; i++) begin
      word[2*i +: 2]    = lane_res[i].status;
      word[2*NB + i]    = lane_res[i].short_ev;
      word[3*NB + i]    = lane_res[i].hold_ev;
    end
  end

  assign space_ok   = (cnt_r != 2'd2);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = buf_r[rd_ptr_r];
  assign pop        = out_tvalid & out_tready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Buffer pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Buffer storage.
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= word;
    end
  end

  `BPHC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `BPHC_ASSERT_NOW(a_no_push_full, push, cnt_r != 2'd2)
  `BPHC_ASSERT_NEXT(a_push_shows, push && !pop, out_tvalid)

endmodule

[hdl/button_press_hold_classifier_core.sv]
// Each button is a lane with its own compare logic; result words are registered in
// the output buffer. Throughput: one tick word per cycle while that buffer is not full.
// A two-word output buffer lets input continue while a result waits to be taken.
// Reset (rst_n low, synchronous): counters, states, timers cleared, registers to defaults.
// Configuration writes are taken every cycle; cfg_ready is always high.
module button_press_hold_classifier_core #(
  parameter int NUM_BUTTONS = bphc_pkg::NUM_BUTTONS_DEF,
  parameter int COUNT_WIDTH = bphc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // level_a[0], level_b[1], level_c[2], elapsed_ms[10:3]
  input  logic [bphc_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // status_a[1:0], status_b[3:2], status_c[5:4], short_event_a..c[8:6],
  // hold_event_a..c[11:9]
  output logic [bphc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bphc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bphc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NB = bphc_pkg::FIELD_BUTTONS;
  localparam int LANES = (NUM_BUTTONS < NB) ? NUM_BUTTONS : NB;

  logic [NB-1:0]                    enable_mask_r;
  bphc_pkg::bphc_cfg_t              cfg_r;
  logic [bphc_pkg::REPEAT_W-1:0]    rep_period_r [NB];
  bphc_pkg::bphc_res_t              lane_res [NB];
  logic                             step;
  logic [bphc_pkg::ELAPSED_W-1:0]   elapsed_ms;

  assign cfg_ready  = 1'b1;
  assign step       = in_tvalid & in_tready;
  assign elapsed_ms = in_tdata[NB +: bphc_pkg::ELAPSED_W];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_mask_r       <= bphc_pkg::ENABLE_MASK_RST;
      cfg_r.bounce_limit  <= bphc_pkg::BOUNCE_LIMIT_RST;
      cfg_r.hold_limit    <= bphc_pkg::HOLD_LIMIT_RST;
      cfg_r.exit_count    <= bphc_pkg::EXIT_COUNT_RST;
      for (int i = 0; i < NB; i++) begin
        rep_period_r[i] <= bphc_pkg::REP_PERIOD_RST;
      end
    end else if (cfg_valid) begin
      case (cfg_index)
        bphc_pkg::REG_ENABLE_MASK:     enable_mask_r <= cfg_data[NB-1:0];
        bphc_pkg::REG_BOUNCE_LIMIT:    cfg_r.bounce_limit <= cfg_data[bphc_pkg::LIMIT_W-1:0];
        bphc_pkg::REG_HOLD_LIMIT:      cfg_r.hold_limit <= cfg_data[bphc_pkg::LIMIT_W-1:0];
        bphc_pkg::REG_EXIT_COUNT:      cfg_r.exit_count <= cfg_data;
        bphc_pkg::REG_REP_PERIOD_A:    rep_period_r[0] <= cfg_data;
        bphc_pkg::REG_REP_PERIOD_B:    rep_period_r[1] <= cfg_data;
        bphc_pkg::REG_REP_PERIOD_C:    rep_period_r[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // One lane per present button; absent buttons report all zeros.
  for (genvar g = 0; g < NB; g++) begin : g_lane
    if (g < LANES) begin : g_on
      bphc_lane #(
        .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .enable     (enable_mask_r[g]),
        .level      (in_tdata[g]),
        .elapsed_ms (elapsed_ms),
        .cfg        (cfg_r),
        .rep_period (rep_period_r[g]),
        .res        (lane_res[g])
      );
    end else begin : g_off
      assign lane_res[g] = '0;
    end
  end

  bphc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .lane_res   (lane_res),
    .space_ok   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
